/* hdl/coapov_pkg.sv */
// Shared types, constants and the option rule table for the CoAP option validator.
package coapov_pkg;

   localparam int NUM_W     = 16;
   localparam int LEN_W     = 16;
   localparam int ERR_W     = 6;
   localparam int PRESENT_W = 19;
   localparam int SEEN_W    = 13;
   localparam int INDEX_W   = $clog2(PRESENT_W);
   localparam int SLOT_W    = $clog2(SEEN_W);
   localparam int MAXLEN_W  = 11;

   // Bit positions in the error mask
   localparam int ERR_LEN      = 0;
   localparam int ERR_CRIT_LEN = 1;
   localparam int ERR_REP      = 2;
   localparam int ERR_CRIT_REP = 3;
   localparam int ERR_UNK      = 4;
   localparam int ERR_CRIT_UNK = 5;

   typedef struct packed {
      logic [NUM_W-1:0] option_number;
      logic [LEN_W-1:0] value_length;
      logic             start_of_set;
      logic             end_of_set;
   } req_type;

   typedef struct packed {
      logic [ERR_W-1:0]     error_mask;
      logic [PRESENT_W-1:0] present_mask;
      logic                 set_done;
   } rsp_type;

   typedef struct packed {
      logic                found;
      logic [INDEX_W-1:0]  index;     // present_mask bit
      logic                min_one;   // minimum length is 1, else 0
      logic [MAXLEN_W-1:0] max_len;
      logic                no_repeat;
      logic [SLOT_W-1:0]   slot;      // seen bitmap bit
   } rule_type;

   function automatic rule_type make_rule(input int idx, input logic min_one,
                                          input int max_len, input logic no_repeat,
                                          input int slot);
      rule_type r;
      r.found     = 1'b1;
      r.index     = INDEX_W'(idx);
      r.min_one   = min_one;
      r.max_len   = MAXLEN_W'(max_len);
      r.no_repeat = no_repeat;
      r.slot      = SLOT_W'(slot);
      return r;
   endfunction

   function automatic rule_type lookup_rule(input logic [NUM_W-1:0] number);
      rule_type r;
      r = '0;
      case (number)
         16'd1:   r = make_rule( 0, 1'b0,    8, 1'b0,  0); // If-Match
         16'd3:   r = make_rule( 1, 1'b1,  255, 1'b1,  0); // Uri-Host
         16'd4:   r = make_rule( 2, 1'b1,    8, 1'b0,  0); // ETag
         16'd5:   r = make_rule( 3, 1'b0,    0, 1'b1,  1); // If-None-Match
         16'd6:   r = make_rule( 4, 1'b0,    3, 1'b1,  2); // Observe
         16'd7:   r = make_rule( 5, 1'b0,    2, 1'b1,  3); // Uri-Port
         16'd8:   r = make_rule( 6, 1'b0,  255, 1'b0,  0); // Location-Path
         16'd11:  r = make_rule( 7, 1'b0,  255, 1'b0,  0); // Uri-Path
         16'd12:  r = make_rule( 8, 1'b0,    2, 1'b1,  4); // Content-Format
         16'd14:  r = make_rule( 9, 1'b0,    4, 1'b1,  5); // Max-Age
         16'd15:  r = make_rule(10, 1'b0,  255, 1'b0,  0); // Uri-Query
         16'd17:  r = make_rule(11, 1'b0,    2, 1'b1,  6); // Accept
         16'd20:  r = make_rule(12, 1'b0,  255, 1'b0,  0); // Location-Query
         16'd23:  r = make_rule(13, 1'b0,    3, 1'b1, 12); // Block2
         16'd27:  r = make_rule(14, 1'b0,    3, 1'b1, 11); // Block1
         16'd28:  r = make_rule(15, 1'b0,    4, 1'b1, 10); // Size2
         16'd35:  r = make_rule(16, 1'b1, 1034, 1'b1,  7); // Proxy-Uri
         16'd39:  r = make_rule(17, 1'b1,  255, 1'b1,  8); // Proxy-Scheme
         16'd60:  r = make_rule(18, 1'b0,    4, 1'b1,  9); // Size1
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* hdl/coap_option_validator.sv */
// CoAP option validator: per-option length, repeat and registry checks with message masks.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | coapov_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_stall | coapov_pkg::rsp_type
//
// One option per cycle unless rsp_stall holds; passes input register, then result register.
// The table lookup, length compare and mask update sit between the two registers.
// Synchronous active-high reset clears both valid flags and the message masks.
// A stalled result holds; the input register keeps taking transactions while the
// result register drains, and req_stall rises only when both registers are full.
module coap_option_validator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  coapov_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output coapov_pkg::rsp_type rsp_data
);
   import coapov_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   req_type              s1_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [SEEN_W-1:0]    seen_ff, seen_in;
   logic [ERR_W-1:0]     error_ff, error_in;
   logic [PRESENT_W-1:0] present_ff, present_in;

   logic                 advance;
   rule_type             rule;
   logic                 crit;
   logic                 len_bad;
   logic                 rep_hit;
   logic [SEEN_W-1:0]    seen_base;
   logic [ERR_W-1:0]     error_base, err_new;
   logic [PRESENT_W-1:0] present_base;

   // Stage 1 moves into the result register when that register is empty or draining
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;

   always_comb begin
      seen_base    = s1_data_ff.start_of_set ? '0 : seen_ff;
      error_base   = s1_data_ff.start_of_set ? '0 : error_ff;
      present_base = s1_data_ff.start_of_set ? '0 : present_ff;

      rule    = lookup_rule(s1_data_ff.option_number);
      crit    = s1_data_ff.option_number[0];
      len_bad = (rule.min_one && (s1_data_ff.value_length == '0)) ||
                (s1_data_ff.value_length > LEN_W'(rule.max_len));
      rep_hit = rule.no_repeat && seen_base[rule.slot];

      err_new = '0;
      if (rule.found) begin
         if (len_bad) begin
            err_new[crit ? ERR_CRIT_LEN : ERR_LEN] = 1'b1;
         end
         if (rep_hit) begin
            err_new[crit ? ERR_CRIT_REP : ERR_REP] = 1'b1;
         end
      end else begin
         err_new[crit ? ERR_CRIT_UNK : ERR_UNK] = 1'b1;
      end

      seen_in    = seen_ff;
      error_in   = error_ff;
      present_in = present_ff;
      if (s1_valid_ff && advance) begin
         error_in   = error_base | err_new;
         present_in = present_base;
         seen_in    = seen_base;
         if (rule.found) begin
            present_in = present_base | (PRESENT_W'(1) << rule.index);
         end
         if (rule.found && rule.no_repeat) begin
            seen_in = seen_base | (SEEN_W'(1) << rule.slot);
         end
      end

      rsp_data_in              = rsp_data_ff;
      rsp_valid_in             = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in             = s1_valid_ff;
         rsp_data_in.error_mask   = error_base | err_new;
         rsp_data_in.present_mask = present_in;
         rsp_data_in.set_done     = s1_data_ff.end_of_set;
      end

      s1_valid_in = s1_valid_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seen_ff      <= '0;
         error_ff     <= '0;
         present_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         seen_ff      <= seen_in;
         error_ff     <= error_in;
         present_ff   <= present_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every non-repeatable option seen also has its own presence bit
   assert property (@(posedge clock) disable iff (reset)
      $countones(seen_ff) <= $countones(present_ff))
      else $error("seen bitmap has more bits than presence mask");

   // Without a start flag, the accumulated masks only gain bits
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && !s1_data_ff.start_of_set) |=>
         (((error_ff & $past(error_ff)) == $past(error_ff)) &&
          ((present_ff & $past(present_ff)) == $past(present_ff))))
      else $error("accumulated mask lost a bit without start flag");

   // A new result only comes from an item held in the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without a pending item");

   // Issued result matches the accumulated state after the update
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance) |=>
         (rsp_data_ff.error_mask == error_ff && rsp_data_ff.present_mask == present_ff))
      else $error("result masks differ from accumulated state");

   // Input is held off only while both the input and result registers are occupied
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("input stalled with free space");

endmodule
